>>> sv/stds_pkg.sv
// Shared types and constants for the sorted key table search block.
// Holds table sizing, command and status codes, and the controller/datapath structs.
// No dependencies.
package stds_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int POS_W       = 8;
  localparam int OPS_W       = 9;
  localparam int CAP_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDERED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METHOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

  // Search methods.
  localparam logic [1:0] METH_BINARY    = 2'd0;
  localparam logic [1:0] METH_LINEAR    = 2'd1;
  localparam logic [1:0] METH_TRANSPOSE = 2'd2;

  // Request types.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Datapath operations issued by the controller.
  localparam logic [3:0] CMD_NONE       = 4'd0;
  localparam logic [3:0] CMD_LOAD       = 4'd1;
  localparam logic [3:0] CMD_INS_APPEND = 4'd2;
  localparam logic [3:0] CMD_INS_READ   = 4'd3;
  localparam logic [3:0] CMD_INS_SHIFT  = 4'd4;
  localparam logic [3:0] CMD_INS_PUT    = 4'd5;
  localparam logic [3:0] CMD_LIN_READ   = 4'd6;
  localparam logic [3:0] CMD_LIN_CMP    = 4'd7;
  localparam logic [3:0] CMD_BIN_READ   = 4'd8;
  localparam logic [3:0] CMD_BIN_CMP    = 4'd9;
  localparam logic [3:0] CMD_SWAP_READ  = 4'd10;
  localparam logic [3:0] CMD_SWAP_WRITE = 4'd11;
  localparam logic [3:0] CMD_SWAP_PUT   = 4'd12;
  localparam logic [3:0] CMD_RESULT     = 4'd13;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] st;
  } cmd_t;

  typedef struct packed {
    logic       is_search;
    logic       full;
    logic       ordered;
    logic [1:0] method;
    logic       key_eq;
    logic       key_lt;
    logic       idx_zero;
    logic       lin_end;
    logic       bin_end;
  } stat_t;

endpackage

>>> sv/stds_dp.sv
// Datapath of the sorted key table: key memory, fill count, walk registers,
// configuration registers and result registers. Depends on stds_pkg.
module stds_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  stds_pkg::cmd_t                     cmd,
  output stds_pkg::stat_t                    stat,
  input  logic                               req_type,
  input  logic signed [stds_pkg::KEY_W-1:0]  key,
  input  logic                               cfg_valid,
  input  logic [stds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stds_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [stds_pkg::POS_W-1:0]         position,
  output logic [stds_pkg::OPS_W-1:0]         op_count
);

  logic signed [stds_pkg::KEY_W-1:0] mem [stds_pkg::TABLE_DEPTH];
  logic signed [stds_pkg::KEY_W-1:0] rdata;
  logic signed [stds_pkg::KEY_W-1:0] key_r;
  logic                              req_r;
  logic [stds_pkg::CNT_W-1:0]        entry_count;
  logic [stds_pkg::CNT_W-1:0]        idx;
  logic [stds_pkg::CNT_W-1:0]        lo;
  logic [stds_pkg::CNT_W-1:0]        hi1;
  logic [stds_pkg::CNT_W-1:0]        ops;
  logic                              ordered_mode;
  logic [1:0]                        search_method;
  logic [stds_pkg::CAP_W-1:0]        capacity;

  logic [stds_pkg::CNT_W-1:0]        idx_m1;
  logic [stds_pkg::CNT_W:0]          mid_sum;
  logic [stds_pkg::CNT_W-1:0]        mid;
  logic                              rd_en;
  logic [stds_pkg::ADDR_W-1:0]       rd_addr;
  logic                              we;
  logic [stds_pkg::ADDR_W-1:0]       wa;
  logic signed [stds_pkg::KEY_W-1:0] wd;

  localparam logic [stds_pkg::CNT_W-1:0] CNT_ONE = stds_pkg::CNT_W'(1);

  assign idx_m1  = idx - 1'b1;
  // Midpoint of the live range [lo, hi1); only used while lo < hi1.
  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - 1'b1;
  assign mid     = mid_sum[stds_pkg::CNT_W:1];

  always_comb begin
    stat.is_search = req_r;
    stat.full      = (32'(entry_count) >= 32'(capacity)) ||
                     (32'(entry_count) >= 32'(stds_pkg::TABLE_DEPTH));
    stat.ordered   = ordered_mode;
    stat.method    = search_method;
    stat.key_eq    = (rdata == key_r);
    stat.key_lt    = (key_r < rdata);
    stat.idx_zero  = (idx == '0);
    stat.lin_end   = (idx == entry_count);
    stat.bin_end   = (lo >= hi1);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wa      = idx[stds_pkg::ADDR_W-1:0];
    wd      = key_r;
    case (cmd.op)
      stds_pkg::CMD_INS_READ, stds_pkg::CMD_SWAP_READ: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[stds_pkg::ADDR_W-1:0];
      end
      stds_pkg::CMD_LIN_READ: begin
        rd_en   = 1'b1;
        rd_addr = idx[stds_pkg::ADDR_W-1:0];
      end
      stds_pkg::CMD_BIN_READ: begin
        rd_en   = 1'b1;
        rd_addr = mid[stds_pkg::ADDR_W-1:0];
      end
      stds_pkg::CMD_INS_SHIFT, stds_pkg::CMD_SWAP_WRITE: begin
        we = 1'b1;
        wd = rdata;
      end
      stds_pkg::CMD_INS_PUT, stds_pkg::CMD_INS_APPEND, stds_pkg::CMD_SWAP_PUT: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Walk registers and result payload.
  always_ff @(posedge clk) begin
    case (cmd.op)
      stds_pkg::CMD_LOAD: begin
        key_r <= key;
        req_r <= req_type;
        idx   <= (req_type == stds_pkg::REQ_SEARCH) ? '0 : entry_count;
        lo    <= '0;
        hi1   <= entry_count;
        ops   <= '0;
      end
      stds_pkg::CMD_INS_APPEND: begin
        ops <= CNT_ONE;
      end
      stds_pkg::CMD_INS_SHIFT: begin
        idx <= idx_m1;
        ops <= ops + 1'b1;
      end
      stds_pkg::CMD_SWAP_WRITE: begin
        idx <= idx_m1;
      end
      stds_pkg::CMD_LIN_CMP: begin
        ops <= ops + 1'b1;
        if (!stat.key_eq) begin
          idx <= idx + 1'b1;
        end
      end
      stds_pkg::CMD_BIN_CMP: begin
        ops <= ops + 1'b1;
        if (stat.key_eq) begin
          idx <= mid;
        end else if (stat.key_lt) begin
          hi1 <= mid;
        end else begin
          lo <= mid + 1'b1;
        end
      end
      stds_pkg::CMD_RESULT: begin
        status   <= cmd.st;
        position <= (cmd.st == stds_pkg::ST_OK && req_r == stds_pkg::REQ_SEARCH) ?
                    idx[stds_pkg::POS_W-1:0] : '0;
        op_count <= stds_pkg::OPS_W'(ops);
      end
      default: begin
      end
    endcase
  end

  // Control state: fill count, configuration and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      ordered_mode  <= 1'b1;
      search_method <= stds_pkg::METH_BINARY;
      capacity      <= stds_pkg::CAP_W'(256);
      done          <= 1'b0;
    end else begin
      done <= (cmd.op == stds_pkg::CMD_RESULT);
      if (cmd.op == stds_pkg::CMD_INS_PUT || cmd.op == stds_pkg::CMD_INS_APPEND) begin
        entry_count <= entry_count + 1'b1;
      end
      if (cfg_valid) begin
        case (cfg_index)
          stds_pkg::CFG_ORDERED:  ordered_mode  <= cfg_data[0];
          stds_pkg::CFG_METHOD:   search_method <= cfg_data[1:0];
          stds_pkg::CFG_CAPACITY: capacity      <= cfg_data[stds_pkg::CAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= 32'(stds_pkg::TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.op == stds_pkg::CMD_RESULT))
    else $error("result strobe without a result command");

  a_no_write_on_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == stds_pkg::CMD_INS_PUT || cmd.op == stds_pkg::CMD_INS_APPEND) |->
    !stat.full)
    else $error("insert committed into a full table");

endmodule

>>> sv/stds_ctrl.sv
// Controller state machine for the sorted key table: sequences inserts and
// searches by issuing datapath commands. Depends on stds_pkg.
module stds_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  stds_pkg::stat_t stat,
  output stds_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_INS_RD   = 4'd2;
  localparam logic [3:0] S_INS_CMP  = 4'd3;
  localparam logic [3:0] S_LIN_RD   = 4'd4;
  localparam logic [3:0] S_LIN_CMP  = 4'd5;
  localparam logic [3:0] S_BIN_RD   = 4'd6;
  localparam logic [3:0] S_BIN_CMP  = 4'd7;
  localparam logic [3:0] S_SWAP_RD  = 4'd8;
  localparam logic [3:0] S_SWAP_WR  = 4'd9;
  localparam logic [3:0] S_SWAP_PUT = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = stds_pkg::CMD_NONE;
    cmd.st     = stds_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = stds_pkg::CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_search) begin
          state_next = (stat.method == stds_pkg::METH_BINARY) ? S_BIN_RD : S_LIN_RD;
        end else if (stat.full) begin
          cmd.op     = stds_pkg::CMD_RESULT;
          cmd.st     = stds_pkg::ST_FULL;
          state_next = S_IDLE;
        end else if (!stat.ordered) begin
          cmd.op     = stds_pkg::CMD_INS_APPEND;
          state_next = S_DONE;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.op     = stds_pkg::CMD_INS_PUT;
          state_next = S_DONE;
        end else begin
          cmd.op     = stds_pkg::CMD_INS_READ;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // The entry below moves up while it is larger than the new key.
        if (stat.key_lt) begin
          cmd.op     = stds_pkg::CMD_INS_SHIFT;
          state_next = S_INS_RD;
        end else begin
          cmd.op     = stds_pkg::CMD_INS_PUT;
          state_next = S_DONE;
        end
      end
      S_LIN_RD: begin
        if (stat.lin_end) begin
          cmd.op     = stds_pkg::CMD_RESULT;
          cmd.st     = stds_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          cmd.op     = stds_pkg::CMD_LIN_READ;
          state_next = S_LIN_CMP;
        end
      end
      S_LIN_CMP: begin
        cmd.op = stds_pkg::CMD_LIN_CMP;
        if (!stat.key_eq) begin
          state_next = S_LIN_RD;
        end else if (stat.method == stds_pkg::METH_TRANSPOSE && !stat.idx_zero) begin
          state_next = S_SWAP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SWAP_RD: begin
        cmd.op     = stds_pkg::CMD_SWAP_READ;
        state_next = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        cmd.op     = stds_pkg::CMD_SWAP_WRITE;
        state_next = S_SWAP_PUT;
      end
      S_SWAP_PUT: begin
        cmd.op     = stds_pkg::CMD_SWAP_PUT;
        state_next = S_DONE;
      end
      S_BIN_RD: begin
        if (stat.bin_end) begin
          cmd.op     = stds_pkg::CMD_RESULT;
          cmd.st     = stds_pkg::ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          cmd.op     = stds_pkg::CMD_BIN_READ;
          state_next = S_BIN_CMP;
        end
      end
      S_BIN_CMP: begin
        cmd.op     = stds_pkg::CMD_BIN_CMP;
        state_next = stat.key_eq ? S_DONE : S_BIN_RD;
      end
      S_DONE: begin
        cmd.op     = stds_pkg::CMD_RESULT;
        cmd.st     = stds_pkg::ST_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(cmd.op == stds_pkg::CMD_RESULT))
    else $error("request finished without issuing a result");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == stds_pkg::CMD_LOAD) |-> (state == S_IDLE && start))
    else $error("request loaded outside idle");

endmodule

>>> sv/sorted_table_dictionary_search.sv
// Top level of the sorted key table with binary, linear and transpose search.
// Joins the controller (stds_ctrl) and the datapath (stds_dp); uses stds_pkg.
//
// A request beat is taken when start is high and busy is low; req_type selects insert (0)
// or search (1) of the signed key. Each request gives exactly one result beat: done is high
// for one cycle with status, position and op_count, and the receiver cannot hold it off,
// so it must take the beat in that cycle. The next request may start in the cycle done
// shows. Timing is set by the single-port read of the key memory: every compared entry is
// read in a read state and then compared in a compare state. An insert into a full table
// is refused without a table access; an unordered insert appends the key; an ordered
// insert moves each larger entry up one place, working from the back, and puts the new key
// in the gap. A linear search compares entries from the front until it finds the key or
// runs out (a transpose then swaps the hit one place forward); a binary search with c
// comparisons has c at most log2(n) + 1. Configuration beats (index 0 ordered_mode, 1
// search_method, 2 capacity) are always ready and must only be sent while the block is
// idle. The key memory is not cleared at reset; only filled entries are read.
module sorted_table_dictionary_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic signed [stds_pkg::KEY_W-1:0]   key,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [stds_pkg::POS_W-1:0]          position,
  output logic [stds_pkg::OPS_W-1:0]          op_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stds_pkg::CFG_DATA_W-1:0]     cfg_data
);

  stds_pkg::cmd_t  cmd;
  stds_pkg::stat_t stat;

  // Configuration registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  stds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  stds_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (req_type),
    .key       (key),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .status    (status),
    .position  (position),
    .op_count  (op_count)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_table_dictionary_search: a directed stimulus table,
// then random phases under changing register settings, checked against a predictor and typed answers.
// Depends on stds_pkg and the block's RTL only.
module testbench;

  // Codes that the package leaves out: a search method outside the documented set, and a
  // register index with no register behind it. The block must treat both as the model does.
  localparam logic [1:0]                     METH_SPARE = 2'd3;
  localparam logic [stds_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register write
  localparam int TAIL_CYCLES   = 40;    // quiet cycles after the last result
  localparam int PHASES        = 12;
  localparam int PHASE_BEATS   = 90;

  localparam logic signed [stds_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [stds_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // One result beat, at the widths of the result ports.
  typedef struct packed {
    logic [1:0]                 st;
    logic [stds_pkg::POS_W-1:0] pos;
    logic [stds_pkg::OPS_W-1:0] ops;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  // One row of the directed table: either a request beat, whose answer is typed in when
  // it is obvious, or a register write.
  typedef struct {
    row_kind_e                             kind;
    logic                                  rt;
    logic signed [stds_pkg::KEY_W-1:0]     k;
    bit                                    typed;
    answer_t                               ans;
    logic [stds_pkg::CFG_IDX_W-1:0]        idx;
    logic [stds_pkg::CFG_DATA_W-1:0]       val;
  } plan_row_t;

  // Block ports. Every input holds a known value from time zero on.
  logic                                  clk       = 1'b0;
  logic                                  rst       = 1'b1;
  logic                                  start     = 1'b0;
  logic                                  busy;
  logic                                  req_type  = stds_pkg::REQ_INSERT;
  logic signed [stds_pkg::KEY_W-1:0]     key       = '0;
  logic                                  done;
  logic [1:0]                            status;
  logic [stds_pkg::POS_W-1:0]            position;
  logic [stds_pkg::OPS_W-1:0]            op_count;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [stds_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [stds_pkg::CFG_DATA_W-1:0]       cfg_data  = '0;

  // A typed answer travels with its request beat, so the monitor sees it at acceptance.
  bit                                    hint_typed = 1'b0;
  answer_t                               hint_ans   = '0;

  // The predictor's own copy of the key table, the fill count and the registers.
  logic signed [stds_pkg::KEY_W-1:0]     shadow_keys [stds_pkg::TABLE_DEPTH];
  int                                    fill_count   = 0;
  logic                                  keep_sorted  = 1'b1;
  logic [1:0]                            probe_method = stds_pkg::METH_BINARY;
  logic [stds_pkg::CAP_W-1:0]            cap_limit    = 9'd256;

  // Answers owed by the block, oldest first.
  answer_t                               awaited [$];

  int mismatches = 0;
  int n_inserts  = 0;
  int n_refused  = 0;
  int n_found    = 0;
  int n_missed   = 0;
  int probes_by_method [4] = '{0, 0, 0, 0};
  bit eager = 1'b0;             // when set, the sender never idles between beats

  plan_row_t plan [$];

  sorted_table_dictionary_search DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .key       (key),
    .done      (done),
    .status    (status),
    .position  (position),
    .op_count  (op_count),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Works out the answer to one request and applies its effect to the shadow table.
  // Inserts refuse once the fill reaches the effective capacity, which never exceeds the
  // table depth. Ordered inserts bubble the new key down past every strictly larger key.
  // Searches only ever look at filled entries; any method other than binary is a linear
  // scan, and transposition swaps a hit one place toward the front.
  function automatic answer_t serve_request(logic is_search,
                                            logic signed [stds_pkg::KEY_W-1:0] k);
    answer_t a;
    int      room;
    int      j;
    int      lo;
    int      hi;
    int      mid;
    int      cmp;
    a = '0;
    if (!is_search) begin
      room = (cap_limit < stds_pkg::TABLE_DEPTH) ? cap_limit : stds_pkg::TABLE_DEPTH;
      if (fill_count >= room) begin
        a.st = stds_pkg::ST_FULL;
        return a;
      end
      shadow_keys[fill_count] = k;
      if (keep_sorted) begin
        j = fill_count;
        while (j > 0 && shadow_keys[j-1] > k) begin
          shadow_keys[j]   = shadow_keys[j-1];
          shadow_keys[j-1] = k;
          a.ops = a.ops + 1'b1;
          j--;
        end
      end else begin
        a.ops = stds_pkg::OPS_W'(1);
      end
      fill_count++;
      return a;
    end
    cmp = 0;
    if (probe_method == stds_pkg::METH_BINARY) begin
      lo = 0;
      hi = fill_count - 1;
      while (lo <= hi) begin
        cmp++;
        mid = (lo + hi) / 2;
        if (shadow_keys[mid] == k) begin
          a.pos = stds_pkg::POS_W'(mid);
          a.ops = stds_pkg::OPS_W'(cmp);
          return a;
        end
        if (k < shadow_keys[mid]) hi = mid - 1;
        else lo = mid + 1;
      end
    end else begin
      for (j = 0; j < fill_count; j++) begin
        cmp++;
        if (shadow_keys[j] == k) begin
          if (probe_method == stds_pkg::METH_TRANSPOSE && j != 0) begin
            shadow_keys[j]   = shadow_keys[j-1];
            shadow_keys[j-1] = k;
            j--;
          end
          a.pos = stds_pkg::POS_W'(j);
          a.ops = stds_pkg::OPS_W'(cmp);
          return a;
        end
      end
    end
    a.st  = stds_pkg::ST_NOT_FOUND;
    a.ops = stds_pkg::OPS_W'(cmp);
    return a;
  endfunction

  function automatic plan_row_t req_row(logic rt, logic signed [stds_pkg::KEY_W-1:0] k,
                                        bit typed = 1'b0,
                                        logic [1:0] st = stds_pkg::ST_OK,
                                        int pos = 0, int ops = 0);
    plan_row_t r;
    r       = '{kind: ROW_REQ, rt: rt, k: k, typed: typed, ans: '0, idx: '0, val: '0};
    r.ans   = {st, pos[stds_pkg::POS_W-1:0], ops[stds_pkg::OPS_W-1:0]};
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [stds_pkg::CFG_IDX_W-1:0] idx,
                                        logic [stds_pkg::CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{kind: ROW_REG, rt: stds_pkg::REQ_INSERT, k: '0, typed: 1'b0, ans: '0,
          idx: idx, val: val};
    return r;
  endfunction

  // Key for a search: mostly a stored key, sometimes a neighbor of one (a likely miss that
  // lands between entries), and sometimes any 32-bit value.
  function automatic logic signed [stds_pkg::KEY_W-1:0] pick_probe_key();
    int                                r;
    logic signed [stds_pkg::KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (fill_count == 0 || r >= 80) return $urandom;
    k = shadow_keys[$urandom_range(0, fill_count - 1)];
    if (r >= 60) begin
      if ($urandom_range(0, 1)) k = k + 1;
      else k = k - 1;
    end
    return k;
  endfunction

  // Key for an insert: a narrow band around zero to get duplicates and long shifts, copies
  // of stored keys, the extremes, and full-range values.
  function automatic logic signed [stds_pkg::KEY_W-1:0] pick_stored_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 200) - 100;
    if (r < 45 && fill_count > 0) return shadow_keys[$urandom_range(0, fill_count - 1)];
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("%0t ns: mismatch, %s", $time, what);
  endtask

  // Offers one request beat after a random idle gap and returns at the edge that takes it.
  // start stays high on return, so a back-to-back beat never drops it in between.
  task automatic send_req(logic rt, logic signed [stds_pkg::KEY_W-1:0] k, bit typed,
                          answer_t ans);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= rt;
    key        <= k;
    hint_typed <= typed;
    hint_ans   <= ans;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Register writes only go out while the block is idle: the sender stops, every owed
  // answer comes back, and a few quiet cycles pass before the configuration beat.
  task automatic write_reg(logic [stds_pkg::CFG_IDX_W-1:0] idx,
                           logic [stds_pkg::CFG_DATA_W-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Monitor. Everything here samples at the rising edge, before any nonblocking update of
  // that edge lands, so it sees exactly what the block sees. Result beats are checked
  // before new requests are booked; a result can never belong to a request taken at the
  // same edge, so the oldest entry in the queue is always the right one.
  always @(posedge clk) begin : watch
    answer_t want;
    answer_t got;
    if (!rst) begin
      if (done === 1'b1) begin
        got = {status, position, op_count};
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing owed (status %0d pos %0d ops %0d)",
                                  status, position, op_count));
        end else begin
          want = awaited.pop_front();
          if (got.st !== want.st)
            flag_mismatch($sformatf("status %0d, wanted %0d", got.st, want.st));
          if (got.pos !== want.pos)
            flag_mismatch($sformatf("position %0d, wanted %0d", got.pos, want.pos));
          if (got.ops !== want.ops)
            flag_mismatch($sformatf("op_count %0d, wanted %0d", got.ops, want.ops));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stds_pkg::CFG_ORDERED:  keep_sorted  = cfg_data[0];
          stds_pkg::CFG_METHOD:   probe_method = cfg_data[1:0];
          stds_pkg::CFG_CAPACITY: cap_limit    = cfg_data;
          default:                ;
        endcase
      end
      if (start && !busy) begin
        want = serve_request(req_type == stds_pkg::REQ_SEARCH, key);
        if (req_type == stds_pkg::REQ_SEARCH) begin
          probes_by_method[probe_method]++;
          if (want.st == stds_pkg::ST_OK) n_found++;
          else n_missed++;
        end else begin
          n_inserts++;
          if (want.st == stds_pkg::ST_FULL) n_refused++;
        end
        awaited.push_back(hint_typed ? hint_ans : want);
      end
    end
  end

  // Stimulus: reset, the directed table, random phases, then the drain and the verdict.
  initial begin : stimulus
    logic [1:0]                      method_cycle [4];
    logic [stds_pkg::CFG_DATA_W-1:0] room;
    int                              ins_pct;
    method_cycle = '{stds_pkg::METH_BINARY, stds_pkg::METH_LINEAR,
                     stds_pkg::METH_TRANSPOSE, METH_SPARE};

    // Directed table, starting from the reset settings: ordered, binary, full capacity.
    // An empty table answers not found without a single comparison.
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, '0, 1'b1, stds_pkg::ST_NOT_FOUND, 0, 0));
    // The key extremes go in first; each later smaller key shifts past larger ones.
    plan.push_back(req_row(stds_pkg::REQ_INSERT, KEY_MAX, 1'b1, stds_pkg::ST_OK, 0, 0));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, KEY_MIN, 1'b1, stds_pkg::ST_OK, 0, 1));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, '0, 1'b1, stds_pkg::ST_OK, 0, 1));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, -1));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, '0));      // duplicate stops at its twin
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MIN));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MAX));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, 12345));
    // One slot left, then a full table; then capacity lowered below the fill.
    plan.push_back(reg_row(stds_pkg::CFG_CAPACITY, 9'd6));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, 7));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, 8, 1'b1, stds_pkg::ST_FULL, 0, 0));
    plan.push_back(reg_row(stds_pkg::CFG_CAPACITY, 9'd0));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, 1, 1'b1, stds_pkg::ST_FULL, 0, 0));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, 7));      // still sees all entries
    // Linear search, then transposition of a hit toward the front, then the spare method.
    plan.push_back(reg_row(stds_pkg::CFG_METHOD,
                           stds_pkg::CFG_DATA_W'(stds_pkg::METH_LINEAR)));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MAX));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, 99));
    plan.push_back(reg_row(stds_pkg::CFG_METHOD,
                           stds_pkg::CFG_DATA_W'(stds_pkg::METH_TRANSPOSE)));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MAX));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MAX));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, KEY_MIN)); // a hit at the front stays put
    plan.push_back(reg_row(stds_pkg::CFG_METHOD, stds_pkg::CFG_DATA_W'(METH_SPARE)));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, 7));
    // Unordered append with capacity above the table depth, then binary search on a table
    // that is no longer sorted, and a write to an index with no register behind it.
    plan.push_back(reg_row(stds_pkg::CFG_ORDERED, 9'd0));
    plan.push_back(reg_row(stds_pkg::CFG_CAPACITY, 9'd511));
    plan.push_back(req_row(stds_pkg::REQ_INSERT, -5, 1'b1, stds_pkg::ST_OK, 0, 1));
    plan.push_back(reg_row(stds_pkg::CFG_METHOD,
                           stds_pkg::CFG_DATA_W'(stds_pkg::METH_BINARY)));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, -5));
    plan.push_back(reg_row(CFG_SPARE, 9'd511));
    plan.push_back(req_row(stds_pkg::REQ_SEARCH, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].val);
      else send_req(plan[i].rt, plan[i].k, plan[i].typed, plan[i].ans);
    end

    // Random phases. The table only ever grows, so capacity is mostly raised step by step while
    // the early phases keep inserts ordered; phases 2 and 6 set it below the fill, and the
    // later phases fill it to the depth, mix in appends and hammer the full table. Each
    // phase has its own method, its own insert share and its own idling style.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(stds_pkg::CFG_ORDERED,
                (p < 5) ? 9'd1 : stds_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(stds_pkg::CFG_METHOD, stds_pkg::CFG_DATA_W'(method_cycle[p % 4]));
      case (p)
        2:       room = 9'd0;
        4:       room = 9'd511;
        6:       room = 9'd1;
        default: begin
          if (p >= 9) room = 9'd256;
          else room = (fill_count + 48 > stds_pkg::TABLE_DEPTH) ? 9'd256 :
                      stds_pkg::CFG_DATA_W'(fill_count + $urandom_range(8, 48));
        end
      endcase
      write_reg(stds_pkg::CFG_CAPACITY, room);
      eager   = ($urandom_range(0, 3) == 0);
      ins_pct = $urandom_range(15, 45);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 99) < ins_pct)
          send_req(stds_pkg::REQ_INSERT, pick_stored_key(), 1'b0, '0);
        else
          send_req(stds_pkg::REQ_SEARCH, pick_probe_key(), 1'b0, '0);
      end
    end

    // Drain: stop sending, collect every owed answer, and watch a while for strays.
    start <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d inserts (%0d refused as full) and %0d searches (%0d hits, %0d misses).",
             n_inserts, n_refused, n_found + n_missed, n_found, n_missed);
    $display("Searches by method binary/linear/transpose/spare: %0d/%0d/%0d/%0d; final fill %0d.",
             probes_by_method[0], probes_by_method[1], probes_by_method[2],
             probes_by_method[3], fill_count);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog. The slowest correct run is about 1100 beats, near 7 ms; this allows several
  // times that.
  initial begin : watchdog
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
sv/stds_pkg.sv
sv/stds_dp.sv
sv/stds_ctrl.sv
sv/sorted_table_dictionary_search.sv
tb/testbench.sv
